// ===== hw/rtl/arf_pkg.sv =====
`timescale 1ns / 1ps

package arf_pkg;

   // coefficient format, signed q2.14
   localparam int COEF_BITS = 16;
   localparam int COEF_FRAC = 14;

   // bit counter over one coefficient
   localparam int BIT_W = 4;
   localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(COEF_BITS - 1);

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int ORDER_W = 3;
   localparam int NUM_AR_REGS = 4;
   localparam int NUM_MA_REGS = 3;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_AR_TAP_0 = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_AR_TAP_1 = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_AR_TAP_2 = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_AR_TAP_3 = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_MA_TAP_0 = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_MA_TAP_1 = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_MA_TAP_2 = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_AR_ORDER = 3'd7;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_MAC    = 3'b010,
      ST_FINISH = 3'b100
   } st_type;

endpackage

// ===== hw/rtl/arma_residual_filter_top.sv =====
`timescale 1ns / 1ps

// a warm-up item only enters the sample history and gives no result; any other item runs
//   the multiply-accumulate over every tap, then the finish step, which registers its result
// no new item is taken until the finish step hands its result on; the bit-serial
//   multiply-accumulate walks each 16-bit coefficient one bit per cycle, tap by tap
// reset: synchronous, active high; clears coefficients, order, both histories, warm-up count
module arma_residual_filter_top #(
   parameter int AR_TAPS = 4,
   parameter int MA_TAPS = 3,
   parameter int SAMPLE_BITS = 16
) (
   input  logic clock,
   input  logic reset,

   // input items
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] req_tdata,  // sample_in
   input  logic [0:0]                            req_tuser,  // series_start

   // result items
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] rsp_tdata,  // residual
   output logic [0:0]                            rsp_tuser,  // saturated

   // configuration writes
   input  logic                                  csr_wen,
   input  logic [arf_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [arf_pkg::COEF_BITS-1:0]         csr_wdata
);

   localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int NTAPS = AR_TAPS + MA_TAPS;
   localparam int TAP_W = $clog2(NTAPS);
   localparam int AR_IW = (AR_TAPS > 1) ? $clog2(AR_TAPS) : 1;
   localparam int MA_IW = (MA_TAPS > 1) ? $clog2(MA_TAPS) : 1;
   localparam int ACC_W = arf_pkg::COEF_BITS + SAMPLE_BITS + TAP_W + 1;
   localparam int CMP_W = (TAP_W > arf_pkg::ORDER_W) ? TAP_W : arf_pkg::ORDER_W;
   localparam int AR_CAP = (AR_TAPS > 7) ? 7 : AR_TAPS;
   localparam logic [arf_pkg::ORDER_W-1:0] ORD_CAP = arf_pkg::ORDER_W'(AR_CAP);
   localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(NTAPS - 1);
   localparam logic [TAP_W-1:0] TAP_MA0 = TAP_W'(AR_TAPS);
   localparam logic signed [ACC_W-1:0] ACC_INIT = ACC_W'(1) <<< (arf_pkg::COEF_FRAC - 1);
   localparam logic signed [ACC_W-1:0] RES_HI =
      {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] RES_LO =
      {{(ACC_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

   // control state
   arf_pkg::st_type state_ff, state_in;
   logic [TAP_W-1:0] tap_ff, tap_in;
   logic [arf_pkg::BIT_W-1:0] bit_ff, bit_in;
   logic [arf_pkg::ORDER_W-1:0] warmup_ff, warmup_in;
   logic rsp_valid_ff, rsp_valid_in;

   // configuration
   logic signed [arf_pkg::COEF_BITS-1:0] ar_coef_ff [AR_TAPS];
   logic signed [arf_pkg::COEF_BITS-1:0] ar_coef_in [AR_TAPS];
   logic signed [arf_pkg::COEF_BITS-1:0] ma_coef_ff [MA_TAPS];
   logic signed [arf_pkg::COEF_BITS-1:0] ma_coef_in [MA_TAPS];
   logic [arf_pkg::ORDER_W-1:0] ar_order_ff, ar_order_in;

   // histories
   logic signed [SAMPLE_BITS-1:0] samp_hist_ff [AR_TAPS];
   logic signed [SAMPLE_BITS-1:0] samp_hist_in [AR_TAPS];
   logic signed [SAMPLE_BITS-1:0] res_hist_ff [MA_TAPS];
   logic signed [SAMPLE_BITS-1:0] res_hist_in [MA_TAPS];

   // datapath
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] mcand_ff, mcand_in;
   logic [arf_pkg::COEF_BITS-1:0] coef_sr_ff, coef_sr_in;
   logic [SAMPLE_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic rsp_sat_ff, rsp_sat_in;

   logic req_fire, finish_fire, out_free, warm_now;
   logic [arf_pkg::ORDER_W-1:0] order_eff, warm_base;
   logic tap_is_ar, tap_used;
   logic [AR_IW-1:0] ar_idx;
   logic [TAP_W-1:0] ma_off;
   logic [MA_IW-1:0] ma_idx;
   logic signed [SAMPLE_BITS-1:0] hist_val;
   logic signed [arf_pkg::COEF_BITS-1:0] coef_val;
   logic signed [ACC_W-1:0] mcand_cur, addend, quot, diff;
   logic [arf_pkg::COEF_BITS-1:0] coef_cur;
   logic sat_hi, sat_lo;
   logic signed [SAMPLE_BITS-1:0] res_val;

   // handshakes
   assign req_tready = (state_ff == arf_pkg::ST_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign finish_fire = (state_ff == arf_pkg::ST_FINISH) && out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = DATA_W'(rsp_data_ff);
   assign rsp_tuser = rsp_sat_ff;

   // effective order and warm-up decision, history cleared at series start
   assign order_eff = (ar_order_ff > ORD_CAP) ? ORD_CAP : ar_order_ff;
   assign warm_base = req_tuser[0] ? '0 : warmup_ff;
   assign warm_now = warm_base < order_eff;

   // tap selection for the serial multiply
   assign tap_is_ar = tap_ff < TAP_MA0;
   assign ar_idx = tap_ff[AR_IW-1:0];
   assign ma_off = tap_ff - TAP_MA0;
   assign ma_idx = ma_off[MA_IW-1:0];
   assign tap_used = !tap_is_ar || (CMP_W'(tap_ff) < CMP_W'(order_eff));
   assign hist_val = tap_is_ar ? samp_hist_ff[ar_idx] : res_hist_ff[ma_idx];
   assign coef_val = tap_is_ar ? ar_coef_ff[ar_idx] : ma_coef_ff[ma_idx];

   // one coefficient bit per cycle, lsb first; the sign bit weighs negative
   always_comb begin
      if (bit_ff == '0) begin
         mcand_cur = tap_used ?
            $signed({{(ACC_W - SAMPLE_BITS){hist_val[SAMPLE_BITS-1]}}, hist_val}) : '0;
         coef_cur = coef_val;
      end else begin
         mcand_cur = mcand_ff;
         coef_cur = coef_sr_ff;
      end
      addend = coef_cur[0] ? mcand_cur : '0;
   end

   // rounding offset already sits in the accumulator, so this is a floor shift
   always_comb begin
      quot = acc_ff >>> arf_pkg::COEF_FRAC;
      diff = $signed({{(ACC_W - SAMPLE_BITS){sample_ff[SAMPLE_BITS-1]}}, sample_ff}) - quot;
      sat_hi = diff > RES_HI;
      sat_lo = diff < RES_LO;
      if (sat_hi) begin
         res_val = RES_HI[SAMPLE_BITS-1:0];
      end else if (sat_lo) begin
         res_val = RES_LO[SAMPLE_BITS-1:0];
      end else begin
         res_val = diff[SAMPLE_BITS-1:0];
      end
   end

   // sequencer and datapath next values
   always_comb begin
      state_in = state_ff;
      tap_in = tap_ff;
      bit_in = bit_ff;
      sample_in = sample_ff;
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      coef_sr_in = coef_sr_ff;
      unique case (state_ff)
         arf_pkg::ST_IDLE: begin
            if (req_fire && !warm_now) begin
               state_in = arf_pkg::ST_MAC;
               sample_in = req_tdata[SAMPLE_BITS-1:0];
               acc_in = ACC_INIT;
               tap_in = '0;
               bit_in = '0;
            end
         end
         arf_pkg::ST_MAC: begin
            mcand_in = mcand_cur <<< 1;
            coef_sr_in = coef_cur >> 1;
            if (bit_ff == arf_pkg::BIT_LAST) begin
               acc_in = acc_ff - addend;
               bit_in = '0;
               if (tap_ff == TAP_LAST) begin
                  state_in = arf_pkg::ST_FINISH;
               end else begin
                  tap_in = tap_ff + 1'b1;
               end
            end else begin
               acc_in = acc_ff + addend;
               bit_in = bit_ff + 1'b1;
            end
         end
         arf_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = arf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = arf_pkg::ST_IDLE;
         end
      endcase
   end

   // histories and warm-up count
   always_comb begin
      samp_hist_in = samp_hist_ff;
      res_hist_in = res_hist_ff;
      warmup_in = warmup_ff;
      if (req_fire) begin
         if (req_tuser[0]) begin
            for (int i = 0; i < AR_TAPS; i++) samp_hist_in[i] = '0;
            for (int i = 0; i < MA_TAPS; i++) res_hist_in[i] = '0;
            warmup_in = '0;
         end
         if (warm_now) begin
            for (int i = AR_TAPS - 1; i > 0; i--) samp_hist_in[i] = samp_hist_in[i-1];
            samp_hist_in[0] = req_tdata[SAMPLE_BITS-1:0];
            warmup_in = warm_base + 1'b1;
         end
      end
      if (finish_fire) begin
         for (int i = AR_TAPS - 1; i > 0; i--) samp_hist_in[i] = samp_hist_ff[i-1];
         samp_hist_in[0] = sample_ff;
         for (int i = MA_TAPS - 1; i > 0; i--) res_hist_in[i] = res_hist_ff[i-1];
         res_hist_in[0] = res_val;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      rsp_sat_in = rsp_sat_ff;
      if (finish_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = res_val;
         rsp_sat_in = sat_hi || sat_lo;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // configuration writes
   always_comb begin
      ar_coef_in = ar_coef_ff;
      ma_coef_in = ma_coef_ff;
      ar_order_in = ar_order_ff;
      if (csr_wen) begin
         for (int i = 0; i < AR_TAPS; i++) begin
            if (i < arf_pkg::NUM_AR_REGS && int'(csr_addr) == int'(arf_pkg::CSR_AR_TAP_0) + i) begin
               ar_coef_in[i] = csr_wdata;
            end
         end
         for (int i = 0; i < MA_TAPS; i++) begin
            if (i < arf_pkg::NUM_MA_REGS && int'(csr_addr) == int'(arf_pkg::CSR_MA_TAP_0) + i) begin
               ma_coef_in[i] = csr_wdata;
            end
         end
         if (csr_addr == arf_pkg::CSR_AR_ORDER) begin
            ar_order_in = csr_wdata[arf_pkg::ORDER_W-1:0];
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= arf_pkg::ST_IDLE;
         tap_ff <= '0;
         bit_ff <= '0;
         warmup_ff <= '0;
         rsp_valid_ff <= 1'b0;
         ar_order_ff <= '0;
         for (int i = 0; i < AR_TAPS; i++) begin
            ar_coef_ff[i] <= '0;
            samp_hist_ff[i] <= '0;
         end
         for (int i = 0; i < MA_TAPS; i++) begin
            ma_coef_ff[i] <= '0;
            res_hist_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         tap_ff <= tap_in;
         bit_ff <= bit_in;
         warmup_ff <= warmup_in;
         rsp_valid_ff <= rsp_valid_in;
         ar_order_ff <= ar_order_in;
         ar_coef_ff <= ar_coef_in;
         ma_coef_ff <= ma_coef_in;
         samp_hist_ff <= samp_hist_in;
         res_hist_ff <= res_hist_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      coef_sr_ff <= coef_sr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   // a non-warm-up item starts the multiply on the next cycle
   a_start_mac: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !warm_now) |=> (state_ff == arf_pkg::ST_MAC && tap_ff == '0 && bit_ff == '0))
      else $error("item did not start the multiply-accumulate");

   // warm-up count never passes the largest usable order
   a_warm_cap: assert property (@(posedge clock) disable iff (reset)
      warmup_ff <= ORD_CAP)
      else $error("warm-up count beyond order cap");

   // a clipped result sits at one end of the range
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |->
         (rsp_tdata[SAMPLE_BITS-1:0] == RES_HI[SAMPLE_BITS-1:0] ||
          rsp_tdata[SAMPLE_BITS-1:0] == RES_LO[SAMPLE_BITS-1:0]))
      else $error("saturated flag on an unclipped residual");

   // the finish step never overwrites a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready && state_ff == arf_pkg::ST_FINISH) |=>
         (state_ff == arf_pkg::ST_FINISH))
      else $error("finish step left while the output was stalled");

endmodule

// ===== tb/arma_residual_filter_top_test.sv =====
`timescale 1ns / 1ps

module arma_residual_filter_top_test;

   localparam int AR_TAPS = 4;
   localparam int MA_TAPS = 3;
   localparam int SAMPLE_BITS = 16;
   localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int GAP_MAX = 19;
   localparam int SETTLE_CYCLES = 150;
   localparam int READY_WAIT_MAX = 300;
   localparam int LONG_HOLD_AT = 300;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int NUM_PHASES = 12;
   localparam int PHASE_ITEMS = 161;
   localparam int NUM_ROWS = 38;
   localparam longint SAT_HI = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
   localparam longint SAT_LO = -(longint'(1) << (SAMPLE_BITS - 1));

   typedef enum logic [1:0] {
      ROW_WRITE,
      ROW_ITEM_MODEL,
      ROW_ITEM_GIVEN,
      ROW_ITEM_QUIET
   } row_kind_type;

   typedef enum int {
      MIX_PASS,
      MIX_PURE_AR,
      MIX_PURE_MA,
      MIX_FULL,
      MIX_EXTREME,
      MIX_GENTLE
   } mix_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] residual;
      logic                   saturated;
   } result_type;

   typedef struct packed {
      row_kind_type                   kind;
      logic [arf_pkg::CSR_ADDR_W-1:0] addr;
      logic [DATA_W-1:0]              value;
      logic                           start;
      result_type                     want;
   } row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [DATA_W-1:0]               req_tdata = '0;
   logic [0:0]                      req_tuser = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [DATA_W-1:0]               rsp_tdata;
   logic [0:0]                      rsp_tuser;
   logic                            csr_wen = 1'b0;
   logic [arf_pkg::CSR_ADDR_W-1:0]  csr_addr = '0;
   logic [arf_pkg::COEF_BITS-1:0]   csr_wdata = '0;

   // filter mirror: coefficients, order, histories
   logic signed [arf_pkg::COEF_BITS-1:0] ar_coef_m [AR_TAPS];
   logic signed [arf_pkg::COEF_BITS-1:0] ma_coef_m [MA_TAPS];
   logic [arf_pkg::ORDER_W-1:0]          order_m;
   logic signed [SAMPLE_BITS-1:0]        smp_hist [AR_TAPS];
   logic signed [SAMPLE_BITS-1:0]        res_hist [MA_TAPS];
   logic [arf_pkg::ORDER_W-1:0]          warm_cnt;

   result_type pending_residuals [$];
   int         fail_count = 0;
   int         src_gap_max = GAP_MAX;
   int         sink_gap_max = GAP_MAX;

   logic [SAMPLE_BITS-1:0] rail_samples [4] = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};

   // directed items and register writes, in order
   row_type directed_rows [NUM_ROWS] = '{
      // order 0 after reset: residual is the sample itself
      '{ROW_ITEM_GIVEN, '0, 16'h7fff, 1'b1, '{16'h7fff, 1'b0}},
      '{ROW_ITEM_GIVEN, '0, 16'h8000, 1'b0, '{16'h8000, 1'b0}},
      '{ROW_ITEM_GIVEN, '0, 16'h0000, 1'b0, '{16'h0000, 1'b0}},
      '{ROW_ITEM_GIVEN, '0, 16'hffff, 1'b0, '{16'hffff, 1'b0}},
      // one tap of -2.0 pushes the output into both rails
      '{ROW_WRITE, arf_pkg::CSR_AR_TAP_0, 16'h8000, 1'b0, '0},
      '{ROW_WRITE, arf_pkg::CSR_AR_ORDER, 16'd1, 1'b0, '0},
      '{ROW_ITEM_QUIET, '0, 16'h7fff, 1'b1, '0},
      '{ROW_ITEM_GIVEN, '0, 16'h7fff, 1'b0, '{16'h7fff, 1'b1}},
      '{ROW_ITEM_QUIET, '0, 16'h8000, 1'b1, '0},
      '{ROW_ITEM_GIVEN, '0, 16'h8000, 1'b0, '{16'h8000, 1'b1}},
      // every tap in use, rails among the coefficients
      '{ROW_WRITE, arf_pkg::CSR_AR_TAP_0, 16'h4000, 1'b0, '0},
      '{ROW_WRITE, arf_pkg::CSR_AR_TAP_1, 16'h2000, 1'b0, '0},
      '{ROW_WRITE, arf_pkg::CSR_AR_TAP_2, 16'hf000, 1'b0, '0},
      '{ROW_WRITE, arf_pkg::CSR_AR_TAP_3, 16'h7fff, 1'b0, '0},
      '{ROW_WRITE, arf_pkg::CSR_MA_TAP_0, 16'h7fff, 1'b0, '0},
      '{ROW_WRITE, arf_pkg::CSR_MA_TAP_1, 16'h8000, 1'b0, '0},
      '{ROW_WRITE, arf_pkg::CSR_MA_TAP_2, 16'h1000, 1'b0, '0},
      '{ROW_WRITE, arf_pkg::CSR_AR_ORDER, 16'd4, 1'b0, '0},
      '{ROW_ITEM_MODEL, '0, 16'h03e8, 1'b1, '0},
      '{ROW_ITEM_MODEL, '0, 16'hf830, 1'b0, '0},
      '{ROW_ITEM_MODEL, '0, 16'h0bb8, 1'b0, '0},
      '{ROW_ITEM_MODEL, '0, 16'hf060, 1'b0, '0},
      '{ROW_ITEM_MODEL, '0, 16'h7fff, 1'b0, '0},
      '{ROW_ITEM_MODEL, '0, 16'h8000, 1'b0, '0},
      '{ROW_ITEM_MODEL, '0, 16'h0000, 1'b0, '0},
      // order lowered mid-series, no restart
      '{ROW_WRITE, arf_pkg::CSR_AR_ORDER, 16'd2, 1'b0, '0},
      '{ROW_ITEM_MODEL, '0, 16'h01f4, 1'b0, '0},
      '{ROW_ITEM_MODEL, '0, 16'hfd44, 1'b0, '0},
      // order above the tap count acts as the tap count
      '{ROW_WRITE, arf_pkg::CSR_AR_ORDER, 16'd7, 1'b0, '0},
      '{ROW_ITEM_MODEL, '0, 16'h04d2, 1'b0, '0},
      // order raised mid-series: warm-up picks up where it stood
      '{ROW_WRITE, arf_pkg::CSR_AR_ORDER, 16'd2, 1'b0, '0},
      '{ROW_ITEM_MODEL, '0, 16'h0064, 1'b1, '0},
      '{ROW_ITEM_MODEL, '0, 16'h00c8, 1'b0, '0},
      '{ROW_ITEM_MODEL, '0, 16'h012c, 1'b0, '0},
      '{ROW_WRITE, arf_pkg::CSR_AR_ORDER, 16'd4, 1'b0, '0},
      '{ROW_ITEM_MODEL, '0, 16'h0190, 1'b0, '0},
      '{ROW_ITEM_MODEL, '0, 16'h01f4, 1'b0, '0},
      '{ROW_ITEM_MODEL, '0, 16'h0258, 1'b0, '0}
   };

   arma_residual_filter_top #(
      .AR_TAPS(AR_TAPS),
      .MA_TAPS(MA_TAPS),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wen(csr_wen),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void clear_history();
      foreach (smp_hist[i]) smp_hist[i] = '0;
      foreach (res_hist[i]) res_hist[i] = '0;
      warm_cnt = '0;
   endfunction

   function automatic void push_sample(input logic signed [SAMPLE_BITS-1:0] smp);
      for (int i = AR_TAPS - 1; i > 0; i--) smp_hist[i] = smp_hist[i - 1];
      smp_hist[0] = smp;
   endfunction

   // one sample through the inverse filter; returns 1 when a residual comes out
   function automatic bit predict_residual(input logic signed [SAMPLE_BITS-1:0] smp,
                                           input logic start, output result_type res);
      int unsigned taps;
      longint      acc;
      longint      diff;
      res = '0;
      if (start) clear_history();
      taps = (order_m > AR_TAPS) ? AR_TAPS : order_m;
      // warm-up only fills the sample history
      if (warm_cnt < taps) begin
         push_sample(smp);
         warm_cnt = warm_cnt + 1'b1;
         return 1'b0;
      end
      acc = 0;
      for (int j = 0; j < AR_TAPS; j++)
         if (j < taps) acc += longint'(ar_coef_m[j]) * longint'(smp_hist[j]);
      for (int j = 0; j < MA_TAPS; j++)
         acc += longint'(ma_coef_m[j]) * longint'(res_hist[j]);
      // round half up, then clip to the sample range
      acc = acc + (longint'(1) << (arf_pkg::COEF_FRAC - 1));
      diff = longint'(smp) - (acc >>> arf_pkg::COEF_FRAC);
      if (diff > SAT_HI) begin
         diff = SAT_HI;
         res.saturated = 1'b1;
      end
      if (diff < SAT_LO) begin
         diff = SAT_LO;
         res.saturated = 1'b1;
      end
      res.residual = diff[SAMPLE_BITS-1:0];
      push_sample(smp);
      for (int j = MA_TAPS - 1; j > 0; j--) res_hist[j] = res_hist[j - 1];
      res_hist[0] = diff[SAMPLE_BITS-1:0];
      return 1'b1;
   endfunction

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
   endfunction

   function automatic logic [arf_pkg::COEF_BITS-1:0] rand_coef();
      if ($urandom_range(5, 0) == 0)
         return $urandom_range(1, 0) ? 16'h7fff : 16'h8000;
      return 16'($urandom_range(16'hffff, 0));
   endfunction

   // register write, mirrored into the filter copy
   task automatic write_reg(input logic [arf_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [arf_pkg::COEF_BITS-1:0] value);
      csr_wen <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
      case (addr)
         arf_pkg::CSR_AR_TAP_0: ar_coef_m[0] = value;
         arf_pkg::CSR_AR_TAP_1: ar_coef_m[1] = value;
         arf_pkg::CSR_AR_TAP_2: ar_coef_m[2] = value;
         arf_pkg::CSR_AR_TAP_3: ar_coef_m[3] = value;
         arf_pkg::CSR_MA_TAP_0: ma_coef_m[0] = value;
         arf_pkg::CSR_MA_TAP_1: ma_coef_m[1] = value;
         arf_pkg::CSR_MA_TAP_2: ma_coef_m[2] = value;
         arf_pkg::CSR_AR_ORDER: order_m = value[arf_pkg::ORDER_W-1:0];
         default: ;
      endcase
   endtask

   // offer one item, then record what it should produce
   task automatic send_item(input logic [SAMPLE_BITS-1:0] smp, input logic start,
                            input row_kind_type kind, input result_type given);
      int         gap;
      int         waited;
      bit         hold_idle;
      bit         produced;
      result_type predicted;
      gap = $urandom_range(src_gap_max, 0);
      hold_idle = ($urandom_range(1, 0) == 1);
      if (gap > 0 || hold_idle) req_tvalid <= 1'b0;
      // sometimes let the gap start once the block is free again
      if (hold_idle) begin
         waited = 1;
         @(posedge clock);
         while (!req_tready && waited < READY_WAIT_MAX) begin
            @(posedge clock);
            waited++;
         end
      end
      repeat (gap) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= smp;
      req_tuser <= start;
      do @(posedge clock); while (!req_tready);
      produced = predict_residual(smp, start, predicted);
      case (kind)
         ROW_ITEM_GIVEN: pending_residuals = {pending_residuals, given};
         ROW_ITEM_MODEL: if (produced) pending_residuals = {pending_residuals, predicted};
         default: ;
      endcase
   endtask

   // block idle: all results in, warm-up items drained
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_residuals.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_phase(input mix_type mix);
      logic [arf_pkg::COEF_BITS-1:0] taps [AR_TAPS + MA_TAPS];
      logic [arf_pkg::COEF_BITS-1:0] ord;
      ord = $urandom_range(7, 0);
      for (int t = 0; t < AR_TAPS + MA_TAPS; t++) begin
         case (mix)
            MIX_PASS:    taps[t] = '0;
            MIX_PURE_AR: taps[t] = (t < AR_TAPS) ? rand_coef() : '0;
            MIX_PURE_MA: taps[t] = (t < AR_TAPS) ? '0 : rand_coef();
            MIX_EXTREME: taps[t] = $urandom_range(1, 0) ? 16'h7fff : 16'h8000;
            MIX_GENTLE:  taps[t] = 16'($urandom_range(8191, 0) - 4096);
            default:     taps[t] = rand_coef();
         endcase
      end
      if (mix == MIX_PURE_MA) ord = '0;
      if (mix == MIX_EXTREME) ord = $urandom_range(1, 0) ? 16'd4 : 16'd7;
      write_reg(arf_pkg::CSR_AR_TAP_0, taps[0]);
      write_reg(arf_pkg::CSR_AR_TAP_1, taps[1]);
      write_reg(arf_pkg::CSR_AR_TAP_2, taps[2]);
      write_reg(arf_pkg::CSR_AR_TAP_3, taps[3]);
      write_reg(arf_pkg::CSR_MA_TAP_0, taps[4]);
      write_reg(arf_pkg::CSR_MA_TAP_1, taps[5]);
      write_reg(arf_pkg::CSR_MA_TAP_2, taps[6]);
      write_reg(arf_pkg::CSR_AR_ORDER, ord);
   endtask

   // result checker
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_residuals.size() == 0) begin
            note_failure($sformatf("unexpected item, residual %0d saturated %0b",
                                   $signed(rsp_tdata), rsp_tuser));
         end else begin
            want = pending_residuals.pop_front();
            if (rsp_tdata[SAMPLE_BITS-1:0] !== want.residual)
               note_failure($sformatf("residual expected %0d got %0d",
                                      $signed(want.residual), $signed(rsp_tdata)));
            if (rsp_tuser[0] !== want.saturated)
               note_failure($sformatf("saturated expected %0b got %0b",
                                      want.saturated, rsp_tuser[0]));
         end
      end
   end

   // result receiver: random hold-off counted while an item waits, one long stall
   initial begin
      int hold;
      int taken;
      hold = 0;
      taken = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            taken++;
            hold = (taken == LONG_HOLD_AT) ? LONG_HOLD_CYCLES
                                           : $urandom_range(sink_gap_max, 0);
         end else if (hold > 0 && rsp_tvalid) begin
            hold--;
         end
         rsp_tready <= (hold == 0);
      end
   end

   // run limit
   initial begin
      #(64'd8_000_000);
      $display("** arma_residual_filter_top: FAILED **");
      $finish;
   end

   // stimulus
   initial begin
      row_type                row;
      bit                     busy;
      logic [SAMPLE_BITS-1:0] smp;
      ar_coef_m = '{default: '0};
      ma_coef_m = '{default: '0};
      order_m = '0;
      clear_history();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table
      busy = 1'b0;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_WRITE) begin
            if (busy) wait_idle();
            busy = 1'b0;
            write_reg(row.addr, row.value);
         end else begin
            send_item(row.value, row.start, row.kind, row.want);
            busy = 1'b1;
         end
      end

      // random phases, each with its own settings
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         program_phase(mix_type'(p % 6));
         src_gap_max = (p % 4 == 3) ? 0 : GAP_MAX;
         sink_gap_max = src_gap_max;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            case ($urandom_range(7, 0))
               0:       smp = rail_samples[$urandom_range(3, 0)];
               1, 2, 3: smp = 16'($urandom_range(4000, 0) - 2000);
               default: smp = 16'($urandom_range(16'hffff, 0));
            endcase
            send_item(smp, (k == 0) || ($urandom_range(24, 0) == 0), ROW_ITEM_MODEL, '0);
         end
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("** arma_residual_filter_top: PASSED **");
      end else begin
         $display("** arma_residual_filter_top: FAILED **");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/arf_pkg.sv
hw/rtl/arma_residual_filter_top.sv
tb/arma_residual_filter_top_test.sv
